>>> rtl/ced_pkg.sv
`default_nettype none
package ced_pkg;

  // Depth of the queue between the decoder and the result emitter.
  localparam int unsigned QUEUE_DEPTH = 4;

  // Result status codes.
  localparam logic [1:0] STATUS_OK     = 2'd0;
  localparam logic [1:0] STATUS_RANGE  = 2'd1;
  localparam logic [1:0] STATUS_BADHEX = 2'd2;

  // Characters with a meaning to the decoder.
  localparam logic [7:0] CHAR_BACKSLASH = 8'h5c;
  localparam logic [7:0] CHAR_X         = 8'h78;

  // One decoded character.
  typedef struct packed {
    logic [7:0] value;
    logic [1:0] status;
    logic       used;
  } result_t;

  // All results caused by one input item; the first is always present.
  typedef struct packed {
    result_t first;
    result_t second;
    logic    two;
  } entry_t;

  // Returns {is_digit, digit} for a hex digit of either case.
  function automatic logic [4:0] hex_digit(input logic [7:0] c);
    logic [4:0] r;
    r = 5'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      r = {1'b1, 4'(c - 8'h30)};
    end else if (c >= 8'h61 && c <= 8'h66) begin
      r = {1'b1, 4'(c - 8'h57)};
    end else if (c >= 8'h41 && c <= 8'h46) begin
      r = {1'b1, 4'(c - 8'h37)};
    end
    return r;
  endfunction

  // Maps the byte after a backslash to its character value.
  function automatic logic [7:0] escape_map(input logic [7:0] c);
    logic [7:0] r;
    case (c)
      8'h61: r = 8'd7;   // a
      8'h62: r = 8'd8;   // b
      8'h66: r = 8'd12;  // f
      8'h6e: r = 8'd10;  // n
      8'h72: r = 8'd13;  // r
      8'h74: r = 8'd9;   // t
      8'h76: r = 8'd11;  // v
      default: r = c;
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

>>> rtl/ced_text_if.sv
`default_nettype none
interface ced_text_if;
  logic       valid;
  logic       ready;
  logic [7:0] text_byte;
  logic       end_of_text;

  modport source (output valid, output text_byte, output end_of_text, input ready);
  modport sink (input valid, input text_byte, input end_of_text, output ready);
endinterface
`default_nettype wire

>>> rtl/ced_char_if.sv
`default_nettype none
interface ced_char_if;
  logic       valid;
  logic       ready;
  logic [7:0] decoded_byte;
  logic [1:0] status;
  logic       used_trigger;
  logic       last_result;

  modport source (output valid, output decoded_byte, output status, output used_trigger,
                  output last_result, input ready);
  modport sink (input valid, input decoded_byte, input status, input used_trigger,
                input last_result, output ready);
endinterface
`default_nettype wire

>>> rtl/c_escape_char_decoder.sv
// Each result passes the entry queue and then the output register before it is offered.
// Throughput: one item per cycle while the queue is not full; an item with two results
// holds the output for two transfers; the QUEUE_DEPTH-deep entry queue absorbs the gap.
// Reset (synchronous, active high): plain text mode, numeric value and saturation
// cleared, the queue and the output register emptied.
`default_nettype none
module c_escape_char_decoder #(
  parameter int unsigned QUEUE_DEPTH = ced_pkg::QUEUE_DEPTH
) (
  input  wire        clk,
  input  wire        rst,
  ced_text_if.sink   text,
  ced_char_if.source decoded
);

  logic            push, pop, not_empty, full;
  ced_pkg::entry_t push_entry, head;

  // Decoder: accepts bytes and builds the results of each item.
  ced_front u_front (
    .clk        (clk),
    .rst        (rst),
    .text       (text),
    .queue_full (full),
    .push       (push),
    .push_entry (push_entry)
  );

  // Queue of result entries.
  ced_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .head       (head),
    .not_empty  (not_empty),
    .full       (full)
  );

  // Emitter: sends one result per transfer.
  ced_back u_back (
    .clk       (clk),
    .rst       (rst),
    .head      (head),
    .not_empty (not_empty),
    .pop       (pop),
    .decoded   (decoded)
  );

endmodule
`default_nettype wire

>>> rtl/ced_front.sv
`default_nettype none
module ced_front (
  input  wire              clk,
  input  wire              rst,
  ced_text_if.sink         text,
  input  wire              queue_full,
  output logic             push,
  output ced_pkg::entry_t  push_entry
);

  localparam logic [2:0] MODE_PLAIN     = 3'd0;
  localparam logic [2:0] MODE_ESCAPE    = 3'd1;
  localparam logic [2:0] MODE_HEX_FIRST = 3'd2;
  localparam logic [2:0] MODE_HEX_RUN   = 3'd3;
  localparam logic [2:0] MODE_OCT_RUN   = 3'd4;

  logic [2:0] mode, mode_next;
  logic [7:0] value, value_next;
  logic       sat, sat_next;

  logic             accept;
  logic [1:0]       count;
  logic [7:0]       c;
  logic [4:0]       hex;
  logic             is_oct;
  ced_pkg::result_t plain_res, run_res, badhex_res, flush_res;
  logic             plain_emits;
  logic [2:0]       plain_mode;
  logic [11:0]      hex_sum, oct_sum;

  assign text.ready = !queue_full;
  assign accept = text.valid && text.ready;
  assign c = text.text_byte;
  assign hex = ced_pkg::hex_digit(c);
  assign is_oct = (c[7:3] == 5'b00110);

  // A byte decoded from plain mode.
  always_comb begin
    plain_res.value  = c;
    plain_res.status = ced_pkg::STATUS_OK;
    plain_res.used   = 1'b1;
    plain_emits = (c != ced_pkg::CHAR_BACKSLASH);
    plain_mode  = plain_emits ? MODE_PLAIN : MODE_ESCAPE;
  end

  // The pending numeric value as a result, and the other fixed results.
  always_comb begin
    run_res.value  = value;
    run_res.status = sat ? ced_pkg::STATUS_RANGE : ced_pkg::STATUS_OK;
    run_res.used   = 1'b0;
    badhex_res.value  = 8'd0;
    badhex_res.status = ced_pkg::STATUS_BADHEX;
    badhex_res.used   = 1'b0;
    flush_res.value  = 8'd0;
    flush_res.status = ced_pkg::STATUS_OK;
    flush_res.used   = 1'b0;
  end

  // Shift-add of the next digit.
  assign hex_sum = {value, 4'b0000} + {8'd0, hex[3:0]};
  assign oct_sum = {1'b0, value, 3'b000} + {9'd0, c[2:0]};

  // Mode update and result selection for one item.
  always_comb begin
    mode_next  = mode;
    value_next = value;
    sat_next   = sat;
    count      = 2'd0;
    push_entry.first  = plain_res;
    push_entry.second = plain_res;
    if (text.end_of_text) begin
      mode_next  = MODE_PLAIN;
      value_next = 8'd0;
      sat_next   = 1'b0;
      case (mode)
        MODE_ESCAPE: begin
          push_entry.first = flush_res;
          count = 2'd1;
        end
        MODE_HEX_FIRST: begin
          push_entry.first = badhex_res;
          count = 2'd1;
        end
        MODE_HEX_RUN, MODE_OCT_RUN: begin
          push_entry.first = run_res;
          count = 2'd1;
        end
        default: count = 2'd0;
      endcase
    end else begin
      case (mode)
        MODE_ESCAPE: begin
          if (c == ced_pkg::CHAR_X) begin
            mode_next  = MODE_HEX_FIRST;
            value_next = 8'd0;
            sat_next   = 1'b0;
          end else if (is_oct) begin
            mode_next  = MODE_OCT_RUN;
            value_next = {5'd0, c[2:0]};
            sat_next   = 1'b0;
          end else begin
            mode_next = MODE_PLAIN;
            push_entry.first.value = ced_pkg::escape_map(c);
            count = 2'd1;
          end
        end
        MODE_HEX_FIRST: begin
          if (hex[4]) begin
            mode_next  = MODE_HEX_RUN;
            value_next = {4'd0, hex[3:0]};
            sat_next   = 1'b0;
          end else begin
            push_entry.first = badhex_res;
            value_next = 8'd0;
            sat_next   = 1'b0;
            mode_next  = plain_mode;
            count = plain_emits ? 2'd2 : 2'd1;
          end
        end
        MODE_HEX_RUN, MODE_OCT_RUN: begin
          if (mode == MODE_HEX_RUN && hex[4]) begin
            if (sat || hex_sum[11:8] != 4'd0) begin
              value_next = 8'hff;
              sat_next   = 1'b1;
            end else begin
              value_next = hex_sum[7:0];
            end
          end else if (mode == MODE_OCT_RUN && is_oct) begin
            if (sat || oct_sum[11:8] != 4'd0) begin
              value_next = 8'hff;
              sat_next   = 1'b1;
            end else begin
              value_next = oct_sum[7:0];
            end
          end else begin
            push_entry.first = run_res;
            value_next = 8'd0;
            sat_next   = 1'b0;
            mode_next  = plain_mode;
            count = plain_emits ? 2'd2 : 2'd1;
          end
        end
        default: begin
          mode_next = plain_mode;
          count = plain_emits ? 2'd1 : 2'd0;
        end
      endcase
    end
    push_entry.two = (count == 2'd2);
  end

  assign push = accept && (count != 2'd0);

  // Decoder state.
  always_ff @(posedge clk) begin
    if (rst) begin
      mode  <= MODE_PLAIN;
      value <= 8'd0;
      sat   <= 1'b0;
    end else if (accept) begin
      mode  <= mode_next;
      value <= value_next;
      sat   <= sat_next;
    end
  end

endmodule
`default_nettype wire

>>> rtl/ced_queue.sv
`default_nettype none
module ced_queue #(
  parameter int unsigned DEPTH = ced_pkg::QUEUE_DEPTH
) (
  input  wire                   clk,
  input  wire                   rst,
  input  wire                   push,
  input  wire ced_pkg::entry_t  push_entry,
  input  wire                   pop,
  output ced_pkg::entry_t       head,
  output logic                  not_empty,
  output logic                  full
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  ced_pkg::entry_t slots [DEPTH];
  logic [AW-1:0]   wr_ptr, rd_ptr;
  logic [CW-1:0]   count;

  assign not_empty = (count != CW'(0));
  assign full      = (count == CW'(DEPTH));
  assign head      = slots[rd_ptr];

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + AW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + AW'(1);
      end
      if (push && !pop) begin
        count <= count + CW'(1);
      end else if (pop && !push) begin
        count <= count - CW'(1);
      end
    end
  end

endmodule
`default_nettype wire

>>> rtl/ced_back.sv
`default_nettype none
module ced_back (
  input  wire                   clk,
  input  wire                   rst,
  input  wire ced_pkg::entry_t  head,
  input  wire                   not_empty,
  output logic                  pop,
  ced_char_if.source            decoded
);

  ced_pkg::entry_t  cur;
  logic             cur_valid;
  logic             second;
  logic             last;
  ced_pkg::result_t sel;

  assign last = second || !cur.two;
  assign sel  = second ? cur.second : cur.first;

  // Output register drives the channel directly.
  assign decoded.valid        = cur_valid;
  assign decoded.decoded_byte = sel.value;
  assign decoded.status       = sel.status;
  assign decoded.used_trigger = sel.used;
  assign decoded.last_result  = last;

  // Take the next entry when empty or when the final result leaves.
  assign pop = not_empty && (!cur_valid || (decoded.ready && last));

  always_ff @(posedge clk) begin
    if (pop) begin
      cur <= head;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid <= 1'b0;
      second    <= 1'b0;
    end else if (pop) begin
      cur_valid <= 1'b1;
      second    <= 1'b0;
    end else if (cur_valid && decoded.ready) begin
      if (last) begin
        cur_valid <= 1'b0;
        second    <= 1'b0;
      end else begin
        second <= 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

>>> dv/ced_decode_check.sv
`timescale 1ns / 1ps
module ced_decode_check (
  input  logic clk,
  input  logic rst,
  ced_text_if  text,
  ced_char_if  decoded,
  output int   pending,
  output int   checked,
  output int   failures
);

  localparam int REPORT_LIMIT = 10;

  // Characters that select an escape or a digit.
  localparam logic [7:0] CH_ZERO    = "0";
  localparam logic [7:0] CH_SEVEN   = "7";
  localparam logic [7:0] CH_NINE    = "9";
  localparam logic [7:0] CH_LOW_A   = "a";
  localparam logic [7:0] CH_LOW_B   = "b";
  localparam logic [7:0] CH_LOW_F   = "f";
  localparam logic [7:0] CH_LOW_N   = "n";
  localparam logic [7:0] CH_LOW_R   = "r";
  localparam logic [7:0] CH_LOW_T   = "t";
  localparam logic [7:0] CH_LOW_V   = "v";
  localparam logic [7:0] CH_UP_A    = "A";
  localparam logic [7:0] CH_UP_F    = "F";

  // Control codes produced by the letter escapes.
  localparam logic [7:0] CTRL_BEL = 8'd7;
  localparam logic [7:0] CTRL_BS  = 8'd8;
  localparam logic [7:0] CTRL_HT  = 8'd9;
  localparam logic [7:0] CTRL_LF  = 8'd10;
  localparam logic [7:0] CTRL_VT  = 8'd11;
  localparam logic [7:0] CTRL_FF  = 8'd12;
  localparam logic [7:0] CTRL_CR  = 8'd13;

  localparam int unsigned HEX_RADIX = 16;
  localparam int unsigned OCT_RADIX = 8;

  typedef enum logic [2:0] {
    DEC_PLAIN,
    DEC_ESCAPE,
    DEC_HEX_FIRST,
    DEC_HEX_RUN,
    DEC_OCT_RUN
  } dec_mode_e;

  typedef struct packed {
    logic [7:0] decoded_byte;
    logic [1:0] status;
    logic       used_trigger;
    logic       last_result;
  } dec_char_t;

  // Shadow of the decoder state.
  dec_mode_e  mode;
  logic [7:0] run_value;
  logic       run_saturated;

  dec_char_t  item_chars[$];
  dec_char_t  expected_chars[$];

  function automatic int hex_value(input logic [7:0] c);
    if (c >= CH_ZERO && c <= CH_NINE) return int'(c - CH_ZERO);
    if (c >= CH_LOW_A && c <= CH_LOW_F) return int'(c - CH_LOW_A) + 10;
    if (c >= CH_UP_A && c <= CH_UP_F) return int'(c - CH_UP_A) + 10;
    return -1;
  endfunction

  function automatic void add_char(input logic [7:0] value, input logic [1:0] status,
                                   input logic used);
    dec_char_t ch;
    ch.decoded_byte = value;
    ch.status       = status;
    ch.used_trigger = used;
    ch.last_result  = 1'b0;
    item_chars.push_back(ch);
  endfunction

  function automatic void clear_run();
    run_value     = '0;
    run_saturated = 1'b0;
  endfunction

  function automatic void accumulate(input int unsigned radix, input int unsigned digit);
    int unsigned next_val;
    next_val = run_value * radix + digit;
    if (run_saturated || next_val > 255) begin
      run_value     = 8'hff;
      run_saturated = 1'b1;
    end else begin
      run_value = 8'(next_val);
    end
  endfunction

  function automatic void flush_run();
    add_char(run_value, run_saturated ? ced_pkg::STATUS_RANGE : ced_pkg::STATUS_OK, 1'b0);
    clear_run();
  endfunction

  // A byte seen in plain mode: a backslash opens an escape, anything else passes.
  function automatic void decode_fresh(input logic [7:0] c);
    if (c == ced_pkg::CHAR_BACKSLASH) begin
      mode = DEC_ESCAPE;
    end else begin
      mode = DEC_PLAIN;
      add_char(c, ced_pkg::STATUS_OK, 1'b1);
    end
  endfunction

  // The byte right after a backslash.
  function automatic void decode_after_backslash(input logic [7:0] c);
    logic [7:0] value;
    mode  = DEC_PLAIN;
    value = c;
    case (c)
      CH_LOW_A: value = CTRL_BEL;
      CH_LOW_B: value = CTRL_BS;
      CH_LOW_F: value = CTRL_FF;
      CH_LOW_N: value = CTRL_LF;
      CH_LOW_R: value = CTRL_CR;
      CH_LOW_T: value = CTRL_HT;
      CH_LOW_V: value = CTRL_VT;
      default: ;
    endcase
    if (c == ced_pkg::CHAR_X) begin
      mode = DEC_HEX_FIRST;
      clear_run();
    end else if (c >= CH_ZERO && c <= CH_SEVEN) begin
      mode = DEC_OCT_RUN;
      clear_run();
      run_value = c - CH_ZERO;
    end else begin
      add_char(value, ced_pkg::STATUS_OK, 1'b1);
    end
  endfunction

  // Works out the characters caused by one text transfer and queues them.
  function automatic void predict_item(input logic [7:0] c, input logic eot);
    int d;
    item_chars.delete();
    if (eot) begin
      case (mode)
        DEC_ESCAPE:                add_char(8'd0, ced_pkg::STATUS_OK, 1'b0);
        DEC_HEX_FIRST:             add_char(8'd0, ced_pkg::STATUS_BADHEX, 1'b0);
        DEC_HEX_RUN, DEC_OCT_RUN:  flush_run();
        default: ;
      endcase
      mode = DEC_PLAIN;
      clear_run();
    end else begin
      case (mode)
        DEC_ESCAPE: decode_after_backslash(c);
        DEC_HEX_FIRST: begin
          d = hex_value(c);
          if (d >= 0) begin
            clear_run();
            run_value = 8'(d);
            mode = DEC_HEX_RUN;
          end else begin
            add_char(8'd0, ced_pkg::STATUS_BADHEX, 1'b0);
            clear_run();
            decode_fresh(c);
          end
        end
        DEC_HEX_RUN: begin
          d = hex_value(c);
          if (d >= 0) begin
            accumulate(HEX_RADIX, d);
          end else begin
            flush_run();
            decode_fresh(c);
          end
        end
        DEC_OCT_RUN: begin
          if (c >= CH_ZERO && c <= CH_SEVEN) begin
            accumulate(OCT_RADIX, c - CH_ZERO);
          end else begin
            flush_run();
            decode_fresh(c);
          end
        end
        default: decode_fresh(c);
      endcase
    end
    if (item_chars.size() > 0) item_chars[item_chars.size() - 1].last_result = 1'b1;
    foreach (item_chars[i]) expected_chars.push_back(item_chars[i]);
  endfunction

  // Compares one output transfer with the oldest expected character.
  function automatic void check_char();
    dec_char_t got;
    dec_char_t want;
    got.decoded_byte = decoded.decoded_byte;
    got.status       = decoded.status;
    got.used_trigger = decoded.used_trigger;
    got.last_result  = decoded.last_result;
    checked++;
    if (expected_chars.size() == 0) begin
      failures++;
      if (failures <= REPORT_LIMIT)
        $display("%0t: unexpected character: byte %02h status %0d used %0d last %0d",
                 $time, got.decoded_byte, got.status, got.used_trigger, got.last_result);
      return;
    end
    want = expected_chars.pop_front();
    if (got.decoded_byte !== want.decoded_byte || got.status !== want.status ||
        got.used_trigger !== want.used_trigger || got.last_result !== want.last_result) begin
      failures++;
      if (failures <= REPORT_LIMIT)
        $display("%0t: mismatch: expected byte %02h status %0d used %0d last %0d,",
                 $time, want.decoded_byte, want.status, want.used_trigger, want.last_result,
                 " got byte %02h status %0d used %0d last %0d",
                 got.decoded_byte, got.status, got.used_trigger, got.last_result);
    end
  endfunction

  // Watch both channels at every rising edge.
  always @(posedge clk) begin
    if (rst) begin
      mode = DEC_PLAIN;
      clear_run();
      expected_chars.delete();
    end else begin
      if (text.valid && text.ready) predict_item(text.text_byte, text.end_of_text);
      if (decoded.valid && decoded.ready) check_char();
    end
    pending <= expected_chars.size();
  end

endmodule

>>> dv/tb_top.sv
`timescale 1ns / 1ps
module tb_top;

  localparam int    RESET_CYCLES  = 7;
  localparam int    RANDOM_ITEMS  = 1300;
  localparam int    CALM_ITEMS    = 150;
  localparam int    HOLD_AT_ITEM  = 400;
  localparam int    HOLD_CYCLES   = 100;
  localparam int    DRAIN_CYCLES  = 20;
  localparam int    SHUFFLE_EVERY = 100;
  localparam real   TIMEOUT_NS    = 5_000_000.0;

  localparam logic [7:0] CH_ZERO  = "0";
  localparam logic [7:0] CH_ONE   = "1";
  localparam logic [7:0] CH_SEVEN = "7";
  localparam logic [7:0] CH_NINE  = "9";
  localparam logic [7:0] CH_LOW_A = "a";
  localparam logic [7:0] CH_LOW_F = "f";
  localparam logic [7:0] CH_LOW_T = "t";
  localparam logic [7:0] CH_LOW_N = "n";
  localparam logic [7:0] CH_UP_A  = "A";
  localparam logic [7:0] CH_UP_F  = "F";

  logic clk;
  logic rst;
  int   pending;
  int   checked;
  int   failures;

  int   items_sent;
  int   eot_sent;
  bit   src_idle;
  bit   sink_idle;
  bit   hold_wanted;
  bit   hold_done;
  string esc_letters = "abfnrtv?'";

  ced_text_if text_ch ();
  ced_char_if char_ch ();

  c_escape_char_decoder uut (
    .clk     (clk),
    .rst     (rst),
    .text    (text_ch),
    .decoded (char_ch)
  );

  ced_decode_check decode_check (
    .clk      (clk),
    .rst      (rst),
    .text     (text_ch),
    .decoded  (char_ch),
    .pending  (pending),
    .checked  (checked),
    .failures (failures)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Hard stop in case the decoder hangs.
  initial begin
    #(TIMEOUT_NS);
    $display("FAIL c_escape_char_decoder");
    $finish;
  end

  // Offers one item and returns at the edge where it transfers.
  task automatic send_item(input logic [7:0] c, input logic eot);
    if (src_idle && $urandom_range(0, 5) == 0) begin
      text_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk);
    end
    text_ch.valid       <= 1'b1;
    text_ch.text_byte   <= c;
    text_ch.end_of_text <= eot;
    do @(posedge clk); while (!text_ch.ready);
    items_sent++;
    if (eot) eot_sent++;
    if (items_sent == HOLD_AT_ITEM) hold_wanted = 1'b1;
  endtask

  function automatic logic [7:0] hex_char(input int unsigned v);
    if (v < 10) return CH_ZERO + 8'(v);
    return ($urandom_range(0, 1) ? CH_UP_A : CH_LOW_A) + 8'(v - 10);
  endfunction

  function automatic logic [7:0] non_hex_byte();
    logic [7:0] c;
    do c = 8'($urandom_range(0, 255));
    while ((c >= CH_ZERO && c <= CH_NINE) || (c >= CH_LOW_A && c <= CH_LOW_F) ||
           (c >= CH_UP_A && c <= CH_UP_F));
    return c;
  endfunction

  // One random piece of text: mostly well-formed escapes with random content.
  task automatic send_token();
    int unsigned kind;
    int unsigned n;
    kind = $urandom_range(0, 99);
    if (kind < 30) begin
      send_item(8'($urandom_range(0, 255)), 1'b0);
    end else if (kind < 45) begin
      send_item(ced_pkg::CHAR_BACKSLASH, 1'b0);
      case ($urandom_range(0, 7))
        0, 1:    send_item(8'($urandom_range(0, 255)), 1'b0);
        2:       send_item(ced_pkg::CHAR_BACKSLASH, 1'b0);
        default: send_item(esc_letters[$urandom_range(0, esc_letters.len() - 1)], 1'b0);
      endcase
    end else if (kind < 65) begin
      send_item(ced_pkg::CHAR_BACKSLASH, 1'b0);
      send_item(ced_pkg::CHAR_X, 1'b0);
      n = ($urandom_range(0, 5) == 0) ? $urandom_range(3, 5) : $urandom_range(1, 2);
      repeat (n) send_item(hex_char($urandom_range(0, 15)), 1'b0);
    end else if (kind < 85) begin
      send_item(ced_pkg::CHAR_BACKSLASH, 1'b0);
      repeat ($urandom_range(1, 4)) send_item(CH_ZERO + 8'($urandom_range(0, 7)), 1'b0);
    end else if (kind < 92) begin
      send_item(8'($urandom_range(0, 255)), 1'b1);
    end else if (kind < 97) begin
      send_item(ced_pkg::CHAR_BACKSLASH, 1'b0);
      send_item(ced_pkg::CHAR_X, 1'b0);
      send_item(non_hex_byte(), 1'b0);
    end else begin
      send_item(ced_pkg::CHAR_BACKSLASH, 1'b0);
    end
  endtask

  // Output side: random ready bursts, one long hold-off, steady at the end.
  initial begin
    char_ch.ready <= 1'b0;
    do @(posedge clk); while (rst);
    forever begin
      if (hold_wanted && !hold_done) begin
        char_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_done = 1'b1;
      end else if (!sink_idle || $urandom_range(0, 2) != 0) begin
        char_ch.ready <= 1'b1;
        repeat (sink_idle ? $urandom_range(1, 15) : 1) @(posedge clk);
      end else begin
        char_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 15)) @(posedge clk);
      end
    end
  end

  // Input side: reset, directed text, random text, drain and verdict.
  initial begin
    int next_shuffle;
    int total;
    rst                 <= 1'b1;
    text_ch.valid       <= 1'b0;
    text_ch.text_byte   <= 8'd0;
    text_ch.end_of_text <= 1'b0;
    src_idle    = 1'b1;
    sink_idle   = 1'b1;
    hold_wanted = 1'b0;
    hold_done   = 1'b0;
    items_sent  = 0;
    eot_sent    = 0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    // Zero byte passes through; zero byte and backslash after a backslash.
    send_item(8'h00, 1'b0);
    send_item(ced_pkg::CHAR_BACKSLASH, 1'b0);
    send_item(8'h00, 1'b0);
    send_item(ced_pkg::CHAR_BACKSLASH, 1'b0);
    send_item(ced_pkg::CHAR_BACKSLASH, 1'b0);
    // Hex escape with no digit, then the top byte decoded afresh.
    send_item(ced_pkg::CHAR_BACKSLASH, 1'b0);
    send_item(ced_pkg::CHAR_X, 1'b0);
    send_item(8'hff, 1'b0);
    // Hex run ended by a backslash, octal run ended by a backslash, then a tab.
    send_item(ced_pkg::CHAR_BACKSLASH, 1'b0);
    send_item(ced_pkg::CHAR_X, 1'b0);
    send_item(CH_UP_F, 1'b0);
    send_item(CH_LOW_F, 1'b0);
    send_item(ced_pkg::CHAR_BACKSLASH, 1'b0);
    send_item(CH_ONE, 1'b0);
    send_item(ced_pkg::CHAR_BACKSLASH, 1'b0);
    send_item(CH_LOW_T, 1'b0);
    // Saturating octal run flushed by end of text.
    send_item(ced_pkg::CHAR_BACKSLASH, 1'b0);
    send_item(CH_SEVEN, 1'b0);
    send_item(CH_SEVEN, 1'b0);
    send_item(CH_SEVEN, 1'b0);
    send_item(8'hff, 1'b1);
    // Backslash at end of text, bare hex escape at end of text, end in plain mode.
    send_item(ced_pkg::CHAR_BACKSLASH, 1'b0);
    send_item(8'h00, 1'b1);
    send_item(ced_pkg::CHAR_BACKSLASH, 1'b0);
    send_item(ced_pkg::CHAR_X, 1'b0);
    send_item(8'h5a, 1'b1);
    send_item(CH_LOW_N, 1'b1);

    // Random text, with idling switched per stretch and none at the end.
    total        = items_sent + RANDOM_ITEMS;
    next_shuffle = items_sent;
    while (items_sent < total) begin
      if (items_sent >= total - CALM_ITEMS) begin
        src_idle  = 1'b0;
        sink_idle = 1'b0;
      end else if (items_sent >= next_shuffle) begin
        src_idle     = $urandom_range(0, 3) != 0;
        sink_idle    = $urandom_range(0, 3) != 0;
        next_shuffle = next_shuffle + SHUFFLE_EVERY;
      end
      send_token();
    end
    text_ch.valid <= 1'b0;

    // Let every expected character arrive, then a few more cycles.
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d text items, %0d of them end-of-text markers,", items_sent, eot_sent,
             " with one long output stall.");
    $display("Compared %0d decoded characters; %0d mismatches.", checked, failures);
    if (failures == 0) begin
      $display("PASS c_escape_char_decoder");
    end else begin
      $display("FAIL c_escape_char_decoder");
    end
    $finish;
  end

endmodule
